// File: rtl/core/bdsd1_pkg.sv
// shared types and constants for the beidou d1 subframe assembler
// no dependencies; every rtl file refers to this package by scoped names
`default_nettype none

package bdsd1_pkg;

  // block geometry
  localparam int SAT_COUNT          = 64;
  localparam int WORDS_PER_SUBFRAME = 10;
  localparam int SUBFRAMES          = 3;
  localparam int STORE_DEPTH        = SAT_COUNT * SUBFRAMES * WORDS_PER_SUBFRAME;
  localparam int ADDR_W             = $clog2(STORE_DEPTH);
  localparam int SLOT_W             = 6;
  localparam int SAT_W              = 7;
  localparam int WORD_W             = 30;
  localparam int WIDX_W             = 4;
  localparam int SOW_W              = 20;

  // seconds-of-week checks
  localparam logic [SOW_W-1:0] WEEK_SECONDS = 20'd604800;
  localparam logic [SOW_W-1:0] SOW_STEP     = 20'd6;

  // configuration port
  localparam int PADDR_W    = 4;
  localparam int CFG_DATA_W = 64;

  typedef enum logic {
    REG_GEO_MASK = 1'b0,
    REG_NONE     = 1'b1
  } reg_idx_t;

  typedef logic [WORD_W-1:0] word_t;
  typedef word_t [WORDS_PER_SUBFRAME-1:0] word_arr_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_VUPD,
    ST_SOW_HI,
    ST_SOW_LO,
    ST_SOW_CMP,
    ST_EMIT
  } st_t;

  // store port request from the sequencer
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    word_t             wdata;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  // result of the shared seconds-of-week unit
  typedef struct packed {
    logic             over;
    logic             step_bad;
    logic [SOW_W-1:0] sow;
  } sow_res_t;

endpackage

`default_nettype wire

// File: rtl/core/bdsd1_cfg.sv
// apb-style configuration register holding the geo satellite mask
// depends on bdsd1_pkg
`default_nettype none

module bdsd1_cfg (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [bdsd1_pkg::PADDR_W-1:0]      paddr,
  input  wire logic [bdsd1_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic      [bdsd1_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                                    pready,
  output logic      [bdsd1_pkg::SAT_COUNT-1:0]    geo_mask
);

  bdsd1_pkg::reg_idx_t                      reg_idx;
  logic [bdsd1_pkg::SAT_COUNT-1:0]          mask_r;
  logic [bdsd1_pkg::SAT_COUNT-1:0]          mask_nxt;

  // registers sit on 8-byte boundaries
  assign reg_idx  = bdsd1_pkg::reg_idx_t'(paddr[bdsd1_pkg::PADDR_W-1]);
  assign pready   = 1'b1;
  assign geo_mask = mask_r;

  // write decode
  always_comb begin
    mask_nxt = mask_r;
    if (psel && penable && pwrite && (reg_idx == bdsd1_pkg::REG_GEO_MASK)) begin
      mask_nxt = pwdata[bdsd1_pkg::SAT_COUNT-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '0;
    end else begin
      mask_r <= mask_nxt;
    end
  end

  // read decode
  always_comb begin
    unique case (reg_idx)
      bdsd1_pkg::REG_GEO_MASK: prdata = bdsd1_pkg::CFG_DATA_W'(mask_r);
      default:                 prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/core/bdsd1_store.sv
// subframe word store: one write port, one read port, registered read data
// depends on bdsd1_pkg
`default_nettype none

module bdsd1_store (
  input  wire logic                 clk,
  input  wire bdsd1_pkg::mem_req_t  req,
  output bdsd1_pkg::word_t          rdata
);

  bdsd1_pkg::word_t mem [bdsd1_pkg::STORE_DEPTH];
  bdsd1_pkg::word_t rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // read port
  always_ff @(posedge clk) begin
    rdata_r <= mem[req.raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// File: rtl/core/bdsd1_sow.sv
// shared seconds-of-week unit: assembles the 20-bit value, checks the week
// limit and the 6 s step against the previous subframe; depends on bdsd1_pkg
`default_nettype none

module bdsd1_sow (
  input  wire logic [7:0]                   hi,
  input  wire bdsd1_pkg::word_t             lo_word,
  input  wire logic [bdsd1_pkg::SOW_W-1:0]  prev,
  input  wire logic                         first,
  output bdsd1_pkg::sow_res_t               res
);

  logic [bdsd1_pkg::SOW_W-1:0] sow;
  logic [bdsd1_pkg::SOW_W-1:0] expect_sow;

  // high 8 bits from word 0, low 12 bits from word 1 bits 29:18
  assign sow        = {hi, lo_word[29:18]};
  assign expect_sow = bdsd1_pkg::SOW_W'(prev + bdsd1_pkg::SOW_STEP);

  assign res.sow      = sow;
  assign res.over     = (sow >= bdsd1_pkg::WEEK_SECONDS);
  assign res.step_bad = !first && (sow != expect_sow);

endmodule

`default_nettype wire

// File: rtl/core/bdsd1_seq.sv
// sequencer: subframe capture, store writes, valid bits, time checks and
// word emission; depends on bdsd1_pkg and bdsd1_sow
`default_nettype none

module bdsd1_seq (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic [bdsd1_pkg::SAT_W-1:0]      in_sat_id,
  input  wire bdsd1_pkg::word_arr_t             in_words,
  input  wire logic [bdsd1_pkg::SAT_COUNT-1:0]  geo_mask,
  output bdsd1_pkg::mem_req_t                   mem_req,
  input  wire bdsd1_pkg::word_t                 rdata,
  output logic                                  out_valid,
  output logic      [bdsd1_pkg::SAT_W-1:0]      out_sat,
  output logic      [1:0]                       out_subframe,
  output logic      [bdsd1_pkg::WIDX_W-1:0]     out_word_index,
  output logic                                  out_last
);

  localparam int AW = bdsd1_pkg::ADDR_W;
  localparam int WL = bdsd1_pkg::WORDS_PER_SUBFRAME - 1;

  bdsd1_pkg::st_t                   state_r, state_nxt;
  bdsd1_pkg::word_t                 words_r [bdsd1_pkg::WORDS_PER_SUBFRAME];
  logic [bdsd1_pkg::SAT_W-1:0]      sat_r, sat_nxt;
  logic [bdsd1_pkg::SLOT_W-1:0]     slot_r, slot_nxt;
  logic [1:0]                       sfi_r, sfi_nxt;
  logic [AW-1:0]                    sbase_r, sbase_nxt;
  logic [AW-1:0]                    wptr_r, wptr_nxt;
  logic [AW-1:0]                    rptr_r, rptr_nxt;
  logic [bdsd1_pkg::WIDX_W-1:0]     wcnt_r, wcnt_nxt;
  logic [bdsd1_pkg::WIDX_W-1:0]     widx_r, widx_nxt;
  logic [1:0]                       sf_r, sf_nxt;
  logic [7:0]                       hi_r, hi_nxt;
  logic [bdsd1_pkg::SOW_W-1:0]      prev_r, prev_nxt;
  logic                             mis_r, mis_nxt;
  logic [2:0]                       valid_r [bdsd1_pkg::SAT_COUNT];
  logic                             vwe;
  logic [2:0]                       vdata;
  logic [2:0]                       vnew;
  logic                             ov_r, ov_nxt;
  logic [bdsd1_pkg::SAT_W-1:0]      osat_r, osat_nxt;
  logic [1:0]                       osf_r, osf_nxt;
  logic [bdsd1_pkg::WIDX_W-1:0]     owi_r, owi_nxt;
  logic                             olast_r, olast_nxt;

  // input decode
  logic                             acc;
  logic [bdsd1_pkg::SLOT_W-1:0]     in_slot;
  logic [2:0]                       fid;
  logic [1:0]                       in_sfi;
  logic                             in_ok;
  logic [AW-1:0]                    in_sbase;
  logic [AW-1:0]                    sf_off;
  logic                             emit_last;
  bdsd1_pkg::sow_res_t              sres;

  assign acc      = start && (state_r == bdsd1_pkg::ST_IDLE);
  assign in_slot  = bdsd1_pkg::SLOT_W'(in_sat_id - 1'b1);
  assign fid      = in_words[0][14:12];
  assign in_sfi   = 2'(fid[1:0] - 2'd1);
  assign in_ok    = (in_sat_id != '0)
                 && (in_sat_id <= bdsd1_pkg::SAT_W'(bdsd1_pkg::SAT_COUNT))
                 && !geo_mask[in_slot]
                 && (fid != 3'd0) && !fid[2];
  // slot * 30 as a shift and subtract
  assign in_sbase = AW'({in_slot, 5'b0}) - AW'({in_slot, 1'b0});

  always_comb begin
    case (in_sfi)
      2'd0:    sf_off = AW'(0);
      2'd1:    sf_off = AW'(bdsd1_pkg::WORDS_PER_SUBFRAME);
      default: sf_off = AW'(2 * bdsd1_pkg::WORDS_PER_SUBFRAME);
    endcase
  end

  assign emit_last = (sf_r == 2'd2) && (widx_r == bdsd1_pkg::WIDX_W'(WL));
  assign vnew      = valid_r[slot_r] | (3'b001 << sfi_r);

  // shared compare unit
  bdsd1_sow u_sow (
    .hi      (hi_r),
    .lo_word (rdata),
    .prev    (prev_r),
    .first   (sf_r == 2'd0),
    .res     (sres)
  );

  // next state and outputs
  always_comb begin
    state_nxt     = state_r;
    sat_nxt       = sat_r;
    slot_nxt      = slot_r;
    sfi_nxt       = sfi_r;
    sbase_nxt     = sbase_r;
    wptr_nxt      = wptr_r;
    rptr_nxt      = rptr_r;
    wcnt_nxt      = wcnt_r;
    widx_nxt      = widx_r;
    sf_nxt        = sf_r;
    hi_nxt        = hi_r;
    prev_nxt      = prev_r;
    mis_nxt       = mis_r;
    vwe           = 1'b0;
    vdata         = vnew;
    ov_nxt        = 1'b0;
    osat_nxt      = osat_r;
    osf_nxt       = osf_r;
    owi_nxt       = owi_r;
    olast_nxt     = 1'b0;
    mem_req.we    = 1'b0;
    mem_req.waddr = wptr_r;
    mem_req.wdata = words_r[wcnt_r];
    mem_req.raddr = rptr_r;

    unique case (state_r)
      bdsd1_pkg::ST_IDLE: begin
        if (start && in_ok) begin
          sat_nxt   = in_sat_id;
          slot_nxt  = in_slot;
          sfi_nxt   = in_sfi;
          sbase_nxt = in_sbase;
          wptr_nxt  = AW'(in_sbase + sf_off);
          wcnt_nxt  = '0;
          state_nxt = bdsd1_pkg::ST_WRITE;
        end
      end
      bdsd1_pkg::ST_WRITE: begin
        mem_req.we = 1'b1;
        wptr_nxt   = AW'(wptr_r + 1'b1);
        wcnt_nxt   = bdsd1_pkg::WIDX_W'(wcnt_r + 1'b1);
        if (wcnt_r == bdsd1_pkg::WIDX_W'(WL)) begin
          state_nxt = bdsd1_pkg::ST_VUPD;
        end
      end
      bdsd1_pkg::ST_VUPD: begin
        vwe = 1'b1;
        if (vnew == 3'b111) begin
          rptr_nxt  = sbase_r;
          sf_nxt    = '0;
          mis_nxt   = 1'b0;
          state_nxt = bdsd1_pkg::ST_SOW_HI;
        end else begin
          state_nxt = bdsd1_pkg::ST_IDLE;
        end
      end
      bdsd1_pkg::ST_SOW_HI: begin
        state_nxt = bdsd1_pkg::ST_SOW_LO;
      end
      bdsd1_pkg::ST_SOW_LO: begin
        mem_req.raddr = AW'(rptr_r + 1'b1);
        hi_nxt        = rdata[11:4];
        state_nxt     = bdsd1_pkg::ST_SOW_CMP;
      end
      bdsd1_pkg::ST_SOW_CMP: begin
        if (sres.over) begin
          // the first subframe found past the end of week loses its valid bit
          vwe       = 1'b1;
          vdata     = valid_r[slot_r] & ~(3'b001 << sf_r);
          state_nxt = bdsd1_pkg::ST_IDLE;
        end else begin
          prev_nxt = sres.sow;
          mis_nxt  = mis_r | sres.step_bad;
          if (sf_r == 2'd2) begin
            if (mis_r || sres.step_bad) begin
              state_nxt = bdsd1_pkg::ST_IDLE;
            end else begin
              rptr_nxt  = sbase_r;
              sf_nxt    = '0;
              widx_nxt  = '0;
              state_nxt = bdsd1_pkg::ST_EMIT;
            end
          end else begin
            sf_nxt    = 2'(sf_r + 2'd1);
            rptr_nxt  = AW'(rptr_r + AW'(bdsd1_pkg::WORDS_PER_SUBFRAME));
            state_nxt = bdsd1_pkg::ST_SOW_HI;
          end
        end
      end
      bdsd1_pkg::ST_EMIT: begin
        // read issued now, word shows on the next cycle
        ov_nxt    = 1'b1;
        osat_nxt  = sat_r;
        osf_nxt   = 2'(sf_r + 2'd1);
        owi_nxt   = widx_r;
        olast_nxt = emit_last;
        rptr_nxt  = AW'(rptr_r + 1'b1);
        if (widx_r == bdsd1_pkg::WIDX_W'(WL)) begin
          widx_nxt = '0;
          sf_nxt   = 2'(sf_r + 2'd1);
        end else begin
          widx_nxt = bdsd1_pkg::WIDX_W'(widx_r + 1'b1);
        end
        if (emit_last) begin
          vwe       = 1'b1;
          vdata     = 3'b000;
          state_nxt = bdsd1_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = bdsd1_pkg::ST_IDLE;
      end
    endcase
  end

  // state and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bdsd1_pkg::ST_IDLE;
      ov_r    <= 1'b0;
      olast_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
      olast_r <= olast_nxt;
    end
  end

  // payload and counters
  always_ff @(posedge clk) begin
    sat_r   <= sat_nxt;
    slot_r  <= slot_nxt;
    sfi_r   <= sfi_nxt;
    sbase_r <= sbase_nxt;
    wptr_r  <= wptr_nxt;
    rptr_r  <= rptr_nxt;
    wcnt_r  <= wcnt_nxt;
    widx_r  <= widx_nxt;
    sf_r    <= sf_nxt;
    hi_r    <= hi_nxt;
    prev_r  <= prev_nxt;
    mis_r   <= mis_nxt;
    osat_r  <= osat_nxt;
    osf_r   <= osf_nxt;
    owi_r   <= owi_nxt;
  end

  // capture the subframe words on a start transfer
  always_ff @(posedge clk) begin
    if (acc) begin
      for (int i = 0; i < bdsd1_pkg::WORDS_PER_SUBFRAME; i++) begin
        words_r[i] <= in_words[i];
      end
    end
  end

  // per-satellite valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < bdsd1_pkg::SAT_COUNT; i++) begin
        valid_r[i] <= 3'b000;
      end
    end else if (vwe) begin
      valid_r[slot_r] <= vdata;
    end
  end

  assign busy           = (state_r != bdsd1_pkg::ST_IDLE);
  assign out_valid      = ov_r;
  assign out_sat        = osat_r;
  assign out_subframe   = osf_r;
  assign out_word_index = owi_r;
  assign out_last       = olast_r;

endmodule

`default_nettype wire

// File: rtl/core/bds_d1_subframe_assembler_core.sv
// Top level of the BeiDou D1 subframe assembler. A subframe is taken on a
// start transfer while busy is low. Subframes that are out of range, from a
// masked GEO satellite or with a frame ID other than 1 to 3 are dropped in
// the start cycle and busy never rises. An accepted subframe holds busy
// through ten store writes on the single write port and a valid-bit
// update; when it completes a set, the sequencer reads and checks the three
// seconds-of-week values through one shared compare unit, and a passing set
// is emitted with one store read per word. Each output word is shown for
// exactly one cycle with out_valid, in the cycle after its read, and the 30
// words of a set come in consecutive cycles; the receiver cannot stall. The
// store is not cleared after reset.
// depends on bdsd1_pkg, bdsd1_cfg, bdsd1_store, bdsd1_sow, bdsd1_seq
`default_nettype none

module bds_d1_subframe_assembler_core (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // configuration port
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [bdsd1_pkg::PADDR_W-1:0]      paddr,
  input  wire logic [bdsd1_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic      [bdsd1_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                                    pready,
  // subframe input
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic [bdsd1_pkg::SAT_W-1:0]        in_sat_id,
  input  wire logic [bdsd1_pkg::WORD_W-1:0]       in_word_0,
  input  wire logic [bdsd1_pkg::WORD_W-1:0]       in_word_1,
  input  wire logic [bdsd1_pkg::WORD_W-1:0]       in_word_2,
  input  wire logic [bdsd1_pkg::WORD_W-1:0]       in_word_3,
  input  wire logic [bdsd1_pkg::WORD_W-1:0]       in_word_4,
  input  wire logic [bdsd1_pkg::WORD_W-1:0]       in_word_5,
  input  wire logic [bdsd1_pkg::WORD_W-1:0]       in_word_6,
  input  wire logic [bdsd1_pkg::WORD_W-1:0]       in_word_7,
  input  wire logic [bdsd1_pkg::WORD_W-1:0]       in_word_8,
  input  wire logic [bdsd1_pkg::WORD_W-1:0]       in_word_9,
  // word output
  output logic                                    out_valid,
  output logic      [bdsd1_pkg::SAT_W-1:0]        out_sat,
  output logic      [1:0]                         out_subframe,
  output logic      [bdsd1_pkg::WIDX_W-1:0]       out_word_index,
  output logic      [bdsd1_pkg::WORD_W-1:0]       out_word,
  output logic                                    out_last
);

  logic [bdsd1_pkg::SAT_COUNT-1:0] geo_mask;
  bdsd1_pkg::word_arr_t            in_words;
  bdsd1_pkg::mem_req_t             mem_req;
  bdsd1_pkg::word_t                rdata;

  assign in_words = {in_word_9, in_word_8, in_word_7, in_word_6, in_word_5,
                     in_word_4, in_word_3, in_word_2, in_word_1, in_word_0};

  // configuration register
  bdsd1_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .geo_mask (geo_mask)
  );

  // subframe word store
  bdsd1_store u_store (
    .clk   (clk),
    .req   (mem_req),
    .rdata (rdata)
  );

  // sequencer
  bdsd1_seq u_seq (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_sat_id      (in_sat_id),
    .in_words       (in_words),
    .geo_mask       (geo_mask),
    .mem_req        (mem_req),
    .rdata          (rdata),
    .out_valid      (out_valid),
    .out_sat        (out_sat),
    .out_subframe   (out_subframe),
    .out_word_index (out_word_index),
    .out_last       (out_last)
  );

  assign out_word = rdata;

  // a word only follows a read issued while busy
  a_out_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("output word without a preceding busy cycle");

  // the set ends on word 9 of subframe 3
  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_last |-> (out_valid && (out_subframe == 2'd3) && (out_word_index == 4'd9)))
    else $error("last flag on the wrong word");

  // words of one set come back to back
  a_burst: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |=> out_valid)
    else $error("gap inside an emitted set");

  // no new subframe while a set is being emitted
  a_no_emit_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |-> busy)
    else $error("block idle in the middle of an emission");

endmodule

`default_nettype wire
